### design/assert_macros.svh
// Assertion macros used by b2da_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/b2da_pkg.sv
package b2da_pkg;

    localparam int BIN_W      = 64;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int LEN_W      = 5;
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
    localparam logic [DIGIT_W-1:0] DABBLE_LIM = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    typedef struct packed {
        logic [BIN_W-1:0] value;
        logic             is_signed;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic [LEN_W-1:0]  text_length;
    } out_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DABBLE,
        OP_SHIFT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic negate;
    } ctrl_t;

    typedef struct packed {
        logic valid;
        out_t data;
    } emit_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGITS
    } state_t;

endpackage

### design/b2da_unit.sv
module b2da_unit
    import b2da_pkg::*;
(
    input  logic               clk,
    input  ctrl_t              ctrl,
    input  logic [BIN_W-1:0]   value,
    output logic [DIGIT_W-1:0] top_digit
);

    logic [BIN_W-1:0] bin_reg;
    logic [BIN_W-1:0] bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [BCD_W-1:0] bcd_adj;

    // Shift-and-add-three step: every digit of five or more is corrected
    // before the whole word moves left by one bit.
    always_comb
    begin
        logic [DIGIT_W-1:0] d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[i*DIGIT_W +: DIGIT_W];
            bcd_adj[i*DIGIT_W +: DIGIT_W] = (d >= DABBLE_LIM) ? d + DABBLE_ADD : d;
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
            end
            OP_LOAD:
            begin
                bin_next = ctrl.negate ? (~value) + BIN_W'(1) : value;
                bcd_next = '0;
            end
            OP_DABBLE:
            begin
                bin_next = {bin_reg[BIN_W-2:0], 1'b0};
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            end
            OP_SHIFT:
            begin
                bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

endmodule

### design/b2da_seq.sv
`include "assert_macros.svh"

module b2da_seq
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_t                in_data,
    input  logic               slot_free,
    input  logic [DIGIT_W-1:0] top_digit,
    output ctrl_t              ctrl,
    output emit_t              emit
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             neg_reg;
    logic             neg_next;
    logic             in_neg;

    assign in_neg = in_data.is_signed & in_data.value[BIN_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            len_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            neg_reg   <= neg_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        len_next    = len_reg;
        neg_next    = neg_reg;
        in_ready    = 1'b0;
        ctrl.op     = OP_HOLD;
        ctrl.negate = 1'b0;
        emit        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.op     = OP_LOAD;
                    ctrl.negate = in_neg;
                    neg_next    = in_neg;
                    cnt_next    = '0;
                    state_next  = S_CONV;
                end
            end
            S_CONV:
            begin
                ctrl.op  = OP_DABBLE;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(BIN_W - 1))
                begin
                    rem_next   = LEN_W'(NUM_DIGITS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if ((top_digit == '0) && (rem_reg > LEN_W'(1)))
                begin
                    ctrl.op  = OP_SHIFT;
                    rem_next = rem_reg - LEN_W'(1);
                end
                else
                begin
                    len_next   = rem_reg + LEN_W'(neg_reg);
                    state_next = neg_reg ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    emit.valid          = 1'b1;
                    emit.data.char_code = CHAR_MINUS;
                    state_next          = S_DIGITS;
                end
            end
            S_DIGITS:
            begin
                if (slot_free)
                begin
                    emit.valid          = 1'b1;
                    emit.data.char_code = CHAR_ZERO + CHAR_W'(top_digit);
                    ctrl.op             = OP_SHIFT;
                    rem_next            = rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1))
                    begin
                        emit.data.is_last     = 1'b1;
                        emit.data.text_length = len_reg;
                        state_next            = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_last_ends_text, clk, rst_n, emit.valid && emit.data.is_last, state_reg == S_IDLE)
    `ASSERT_IMPLY(a_rem_nonzero, clk, rst_n, state_reg == S_SIGN || state_reg == S_DIGITS, rem_reg != '0)
    `ASSERT_IMPLY(a_emit_slot, clk, rst_n, emit.valid, slot_free)
    `ASSERT_IMPLY(a_digit_range, clk, rst_n, state_reg == S_DIGITS, top_digit <= 4'd9)

endmodule

### design/binary_to_decimal_ascii_core.sv
// Converts a 64-bit word into its decimal text as ASCII characters.
// Input channel (in_valid, in_ready, in_data): one transaction carries the
// word and a flag that reads it as two's complement signed. Output channel
// (out_valid, out_ready, out_data): one transaction per character, most
// significant first; a negative signed word gets a leading minus sign. The
// final character has is_last set and the total text length, 1 to 20.
// An accepted word passes through a shared shift-and-add-three unit that
// builds 20 decimal digits, one binary bit per cycle; a digit-shift pass in
// that unit then drops leading zeros and emits the characters through the
// output register, one per cycle while the receiver does not stall. A new
// word is accepted only after the last character of the previous one has
// been emitted; in_ready is high only while the block is idle.
// When the receiver stalls, the last character waits in the output register
// and the sequencer holds until it is taken; no character is lost.
// Reset is asynchronous and active low; it returns the block to idle and
// empties the output register.
module binary_to_decimal_ascii_core
    import b2da_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    ctrl_t              ctrl;
    emit_t              emit;
    logic [DIGIT_W-1:0] top_digit;
    logic               slot_free;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_t               out_data_reg;

    assign slot_free      = !out_valid_reg || out_ready;
    assign out_valid_next = emit.valid || (out_valid_reg && !out_ready);

    b2da_unit u_unit (
        .clk       (clk),
        .ctrl      (ctrl),
        .value     (in_data.value),
        .top_digit (top_digit)
    );

    b2da_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .slot_free (slot_free),
        .top_digit (top_digit),
        .ctrl      (ctrl),
        .emit      (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_data_reg <= emit.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
